>>> hw/rtl/scwc_pkg.sv
`timescale 1ns / 1ps

package scwc_pkg;

   localparam int unsigned SEQ_W  = 31;
   localparam int unsigned WIN_W  = 16;
   localparam int unsigned SLOT_W = 7;
   localparam int unsigned DUP_W  = 4;
   localparam int unsigned RTX_W  = 8;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [1:0] CMD_SEND    = 2'd0;
   localparam logic [1:0] CMD_ACK     = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_CAPACITY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_ACK_THRESH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RETRANSMITS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_CLIENT_WIN = 2'd3;

   localparam logic [SLOT_W-1:0] RST_WINDOW_CAPACITY = 7'd64;
   localparam logic [DUP_W-1:0]  RST_DUP_ACK_THRESH  = 4'd3;
   localparam logic [RTX_W-1:0]  RST_MAX_RETRANSMITS = 8'd12;
   localparam logic [WIN_W-1:0]  RST_INIT_CLIENT_WIN = 16'hFFFF;

   localparam logic [WIN_W-1:0] CWND_MAX = 16'hFFFF;
   localparam logic [DUP_W-1:0] DUP_MAX  = 4'hF;
   localparam logic [RTX_W-1:0] RTX_MAX  = 8'hFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RESEND,
      ST_GRANT,
      ST_GROW,
      ST_RESP
   } scwc_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic decode;
      logic resend;
      logic grant;
      logic grow;
   } scwc_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic dec_grant;
      logic dec_grow;
      logic dec_resend;
      logic rsd_grant;
      logic grow_last;
   } scwc_stat_type;

endpackage

>>> hw/rtl/sender_congestion_window_control.sv
`timescale 1ns / 1ps
// From accept, a command passes ST_DECODE and ends in ST_RESP (rsp_valid). A stale ack, a
// duplicate below threshold, a window probe or an unused command go there directly; a send
// opportunity passes ST_GRANT, a retransmit attempt (fast retransmit, timeout, give-up)
// ST_RESEND, plus ST_GRANT for a fresh grant, an ack retiring k segments ST_GROW (one cwnd
// update per cycle), k at most 64 at the default depth. One command in flight: start is taken
// again in the idle cycle after the result beat. Sync active-high reset restores register
// defaults and idle sender state; rsp_valid is a one-cycle strobe, the receiver cannot stall.

module sender_congestion_window_control #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_cmd,
   input  logic [scwc_pkg::SEQ_W-1:0]        req_ack_number,
   input  logic [scwc_pkg::WIN_W-1:0]        req_adv_window,
   input  logic [scwc_pkg::WIN_W-1:0]        req_segments_left,
   output logic                              rsp_valid,
   output logic [scwc_pkg::SLOT_W-1:0]       rsp_new_count,
   output logic [scwc_pkg::SEQ_W-1:0]        rsp_first_new_seq,
   output logic                              rsp_retransmit_now,
   output logic [scwc_pkg::SEQ_W-1:0]        rsp_retransmit_seq,
   output logic                              rsp_probe_now,
   output logic                              rsp_restart_timer,
   output logic                              rsp_gave_up,
   output logic [scwc_pkg::WIN_W-1:0]        rsp_cwnd_now,
   output logic [scwc_pkg::WIN_W-1:0]        rsp_ssthresh_now,
   output logic [scwc_pkg::SLOT_W-1:0]       rsp_in_flight_now,
   input  logic                              csr_wr_en,
   input  logic [scwc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scwc_pkg::WIN_W-1:0]        csr_wdata
);

   scwc_pkg::scwc_ctrl_type ctrl;
   scwc_pkg::scwc_stat_type stat;

   scwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   scwc_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .stat               (stat),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_cmd            (req_cmd),
      .req_ack_number     (req_ack_number),
      .req_adv_window     (req_adv_window),
      .req_segments_left  (req_segments_left),
      .rsp_new_count      (rsp_new_count),
      .rsp_first_new_seq  (rsp_first_new_seq),
      .rsp_retransmit_now (rsp_retransmit_now),
      .rsp_retransmit_seq (rsp_retransmit_seq),
      .rsp_probe_now      (rsp_probe_now),
      .rsp_restart_timer  (rsp_restart_timer),
      .rsp_gave_up        (rsp_gave_up),
      .rsp_cwnd_now       (rsp_cwnd_now),
      .rsp_ssthresh_now   (rsp_ssthresh_now),
      .rsp_in_flight_now  (rsp_in_flight_now)
   );

endmodule

>>> hw/rtl/scwc_ctrl.sv
`timescale 1ns / 1ps

module scwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  scwc_pkg::scwc_stat_type stat,
   output scwc_pkg::scwc_ctrl_type ctrl,
   output logic                   busy,
   output logic                   rsp_valid
);

   scwc_pkg::scwc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scwc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scwc_pkg::ST_IDLE: begin
            if (start) state_in = scwc_pkg::ST_DECODE;
         end
         scwc_pkg::ST_DECODE: begin
            if (stat.dec_grant)       state_in = scwc_pkg::ST_GRANT;
            else if (stat.dec_grow)   state_in = scwc_pkg::ST_GROW;
            else if (stat.dec_resend) state_in = scwc_pkg::ST_RESEND;
            else                      state_in = scwc_pkg::ST_RESP;
         end
         scwc_pkg::ST_RESEND: begin
            if (stat.rsd_grant) state_in = scwc_pkg::ST_GRANT;
            else                state_in = scwc_pkg::ST_RESP;
         end
         scwc_pkg::ST_GRANT: begin
            state_in = scwc_pkg::ST_RESP;
         end
         scwc_pkg::ST_GROW: begin
            if (stat.grow_last) state_in = scwc_pkg::ST_RESP;
         end
         scwc_pkg::ST_RESP: begin
            state_in = scwc_pkg::ST_IDLE;
         end
         default: begin
            state_in = scwc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl      = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         scwc_pkg::ST_IDLE: begin
            busy      = 1'b0;
            ctrl.load = start;
         end
         scwc_pkg::ST_DECODE: ctrl.decode = 1'b1;
         scwc_pkg::ST_RESEND: ctrl.resend = 1'b1;
         scwc_pkg::ST_GRANT:  ctrl.grant  = 1'b1;
         scwc_pkg::ST_GROW:   ctrl.grow   = 1'b1;
         scwc_pkg::ST_RESP:   rsp_valid   = 1'b1;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

>>> hw/rtl/scwc_dp.sv
`timescale 1ns / 1ps

module scwc_dp #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scwc_pkg::scwc_ctrl_type           ctrl,
   output scwc_pkg::scwc_stat_type           stat,
   input  logic                              csr_wr_en,
   input  logic [scwc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [scwc_pkg::WIN_W-1:0]        csr_wdata,
   input  logic [1:0]                        req_cmd,
   input  logic [scwc_pkg::SEQ_W-1:0]        req_ack_number,
   input  logic [scwc_pkg::WIN_W-1:0]        req_adv_window,
   input  logic [scwc_pkg::WIN_W-1:0]        req_segments_left,
   output logic [scwc_pkg::SLOT_W-1:0]       rsp_new_count,
   output logic [scwc_pkg::SEQ_W-1:0]        rsp_first_new_seq,
   output logic                              rsp_retransmit_now,
   output logic [scwc_pkg::SEQ_W-1:0]        rsp_retransmit_seq,
   output logic                              rsp_probe_now,
   output logic                              rsp_restart_timer,
   output logic                              rsp_gave_up,
   output logic [scwc_pkg::WIN_W-1:0]        rsp_cwnd_now,
   output logic [scwc_pkg::WIN_W-1:0]        rsp_ssthresh_now,
   output logic [scwc_pkg::SLOT_W-1:0]       rsp_in_flight_now
);

   localparam int unsigned SEQ_W  = scwc_pkg::SEQ_W;
   localparam int unsigned WIN_W  = scwc_pkg::WIN_W;
   localparam int unsigned SLOT_W = scwc_pkg::SLOT_W;
   localparam int unsigned DUP_W  = scwc_pkg::DUP_W;
   localparam int unsigned RTX_W  = scwc_pkg::RTX_W;
   // the capacity register is 7 bits, so a deeper build never binds
   localparam int unsigned SLOT_TOP = (1 << SLOT_W) - 1;
   localparam logic [SLOT_W-1:0] CAP_MAX =
      (WINDOW_DEPTH > SLOT_TOP) ? SLOT_W'(SLOT_TOP) : SLOT_W'(WINDOW_DEPTH);

   // configuration
   logic [SLOT_W-1:0] capacity_ff, capacity_in;
   logic [DUP_W-1:0]  dup_thresh_ff, dup_thresh_in;
   logic [RTX_W-1:0]  max_rtx_ff, max_rtx_in;
   logic [WIN_W-1:0]  init_win_ff, init_win_in;

   // sender state
   logic [SEQ_W-1:0]  next_seq_ff, next_seq_in;
   logic [SEQ_W-1:0]  expected_ff, expected_in;
   logic [SEQ_W-1:0]  last_ack_ff, last_ack_in;
   logic [SLOT_W-1:0] in_flight_ff, in_flight_in;
   logic [WIN_W-1:0]  cwnd_ff, cwnd_in;
   logic [WIN_W-1:0]  ssthresh_ff, ssthresh_in;
   logic [WIN_W-1:0]  acks_left_ff, acks_left_in;
   logic [DUP_W-1:0]  dup_cnt_ff, dup_cnt_in;
   logic [RTX_W-1:0]  rtx_cnt_ff, rtx_cnt_in;
   logic [WIN_W-1:0]  client_win_ff, client_win_in;

   // latched request
   logic [1:0]        cmd_ff, cmd_in;
   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic [WIN_W-1:0]  adv_ff, adv_in;
   logic [WIN_W-1:0]  left_ff, left_in;
   logic [SLOT_W-1:0] grow_cnt_ff, grow_cnt_in;

   // result
   logic [SLOT_W-1:0] r_new_ff, r_new_in;
   logic [SEQ_W-1:0]  r_first_ff, r_first_in;
   logic              r_rt_ff, r_rt_in;
   logic [SEQ_W-1:0]  r_rtseq_ff, r_rtseq_in;
   logic              r_probe_ff, r_probe_in;
   logic              r_timer_ff, r_timer_in;
   logic              r_gave_ff, r_gave_in;

   // decode helpers
   logic              ack_ge;
   logic [SEQ_W-1:0]  span;
   logic [SLOT_W-1:0] retire_k;
   logic [DUP_W-1:0]  dup_inc;
   logic              dup_fire;
   logic [WIN_W-1:0]  halved;
   // grant helpers
   logic [SLOT_W-1:0] cap;
   logic [WIN_W-1:0]  lim_a, lim;
   logic [WIN_W-1:0]  room;
   logic [SLOT_W-1:0] grant_n;
   logic              grant_ok;
   // growth helpers
   logic [WIN_W-1:0]  al_next;

   always_comb begin
      ack_ge   = ack_ff >= expected_ff;
      span     = ack_ff - expected_ff;
      retire_k = (span >= SEQ_W'(in_flight_ff)) ? in_flight_ff : SLOT_W'(span + 1'b1);
      dup_inc  = (dup_cnt_ff == scwc_pkg::DUP_MAX) ? dup_cnt_ff : dup_cnt_ff + 1'b1;
      dup_fire = !ack_ge && (ack_ff == last_ack_ff) && (dup_inc >= dup_thresh_ff);
      halved   = WIN_W'(({1'b0, cwnd_ff} + 17'd1) >> 1);

      cap      = (capacity_ff > CAP_MAX) ? CAP_MAX : capacity_ff;
      lim_a    = (WIN_W'(cap) < cwnd_ff) ? WIN_W'(cap) : cwnd_ff;
      lim      = (client_win_ff < lim_a) ? client_win_ff : lim_a;
      grant_ok = (left_ff != '0) && (lim > WIN_W'(in_flight_ff));
      room     = lim - WIN_W'(in_flight_ff);
      grant_n  = (room > left_ff) ? SLOT_W'(left_ff) : SLOT_W'(room);

      al_next  = ((acks_left_ff == '0) ? cwnd_ff : acks_left_ff) - 1'b1;
   end

   always_comb begin
      stat.dec_grant  = (cmd_ff == scwc_pkg::CMD_SEND);
      stat.dec_grow   = (cmd_ff == scwc_pkg::CMD_ACK) && ack_ge && (retire_k != '0);
      stat.dec_resend = ((cmd_ff == scwc_pkg::CMD_ACK) && dup_fire) ||
                        ((cmd_ff == scwc_pkg::CMD_TIMEOUT) && (client_win_ff != '0));
      stat.rsd_grant  = (rtx_cnt_ff < max_rtx_ff) && (in_flight_ff == '0) &&
                        (left_ff != '0);
      stat.grow_last  = (grow_cnt_ff == SLOT_W'(1));
   end

   always_comb begin
      capacity_in   = capacity_ff;
      dup_thresh_in = dup_thresh_ff;
      max_rtx_in    = max_rtx_ff;
      init_win_in   = init_win_ff;
      next_seq_in   = next_seq_ff;
      expected_in   = expected_ff;
      last_ack_in   = last_ack_ff;
      in_flight_in  = in_flight_ff;
      cwnd_in       = cwnd_ff;
      ssthresh_in   = ssthresh_ff;
      acks_left_in  = acks_left_ff;
      dup_cnt_in    = dup_cnt_ff;
      rtx_cnt_in    = rtx_cnt_ff;
      client_win_in = client_win_ff;
      cmd_in        = cmd_ff;
      ack_in        = ack_ff;
      adv_in        = adv_ff;
      left_in       = left_ff;
      grow_cnt_in   = grow_cnt_ff;
      r_new_in      = r_new_ff;
      r_first_in    = r_first_ff;
      r_rt_in       = r_rt_ff;
      r_rtseq_in    = r_rtseq_ff;
      r_probe_in    = r_probe_ff;
      r_timer_in    = r_timer_ff;
      r_gave_in     = r_gave_ff;

      if (csr_wr_en) begin
         case (csr_index)
            scwc_pkg::CSR_WINDOW_CAPACITY: capacity_in   = csr_wdata[SLOT_W-1:0];
            scwc_pkg::CSR_DUP_ACK_THRESH:  dup_thresh_in = csr_wdata[DUP_W-1:0];
            scwc_pkg::CSR_MAX_RETRANSMITS: max_rtx_in    = csr_wdata[RTX_W-1:0];
            scwc_pkg::CSR_INIT_CLIENT_WIN: begin
               init_win_in   = csr_wdata;
               client_win_in = csr_wdata;
               ssthresh_in   = csr_wdata;
            end
            default: begin
            end
         endcase
      end

      if (ctrl.load) begin
         cmd_in     = req_cmd;
         ack_in     = req_ack_number;
         adv_in     = req_adv_window;
         left_in    = req_segments_left;
         r_new_in   = '0;
         r_first_in = next_seq_ff;
         r_rt_in    = 1'b0;
         r_rtseq_in = '0;
         r_probe_in = 1'b0;
         r_timer_in = 1'b0;
         r_gave_in  = 1'b0;
      end

      if (ctrl.decode) begin
         case (cmd_ff)
            scwc_pkg::CMD_ACK: begin
               client_win_in = adv_ff;
               if (ack_ge) begin
                  grow_cnt_in  = retire_k;
                  in_flight_in = in_flight_ff - retire_k;
                  r_timer_in   = 1'b1;
                  last_ack_in  = ack_ff;
                  dup_cnt_in   = '0;
                  rtx_cnt_in   = '0;
                  expected_in  = ack_ff + 1'b1;
               end else if (ack_ff == last_ack_ff) begin
                  dup_cnt_in = dup_inc;
                  rtx_cnt_in = '0;
                  if (dup_fire) begin
                     ssthresh_in  = halved;
                     cwnd_in      = halved;
                     acks_left_in = '0;
                     dup_cnt_in   = '0;
                  end
               end
            end
            scwc_pkg::CMD_TIMEOUT: begin
               if (client_win_ff != '0) begin
                  ssthresh_in  = halved;
                  cwnd_in      = WIN_W'(1);
                  acks_left_in = '0;
                  dup_cnt_in   = '0;
               end else begin
                  r_probe_in = 1'b1;
                  r_timer_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (ctrl.resend) begin
         if (rtx_cnt_ff >= max_rtx_ff) begin
            r_gave_in = 1'b1;
         end else begin
            rtx_cnt_in = (rtx_cnt_ff == scwc_pkg::RTX_MAX) ? rtx_cnt_ff : rtx_cnt_ff + 1'b1;
            if (in_flight_ff == '0) begin
               // empty window: a fresh grant replaces the resend when segments are left
               if (left_ff != '0) rtx_cnt_in = '0;
            end else begin
               r_rt_in    = 1'b1;
               r_rtseq_in = next_seq_ff - SEQ_W'(in_flight_ff);
               r_timer_in = 1'b1;
            end
         end
      end

      if (ctrl.grant && grant_ok) begin
         if (in_flight_ff == '0) r_timer_in = 1'b1;
         next_seq_in  = next_seq_ff + SEQ_W'(grant_n);
         in_flight_in = in_flight_ff + grant_n;
         r_new_in     = grant_n;
      end

      if (ctrl.grow) begin
         grow_cnt_in = grow_cnt_ff - 1'b1;
         if (cwnd_ff <= ssthresh_ff) begin
            if (cwnd_ff != scwc_pkg::CWND_MAX) cwnd_in = cwnd_ff + 1'b1;
         end else begin
            acks_left_in = al_next;
            if ((al_next == '0) && (cwnd_ff != scwc_pkg::CWND_MAX)) cwnd_in = cwnd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= scwc_pkg::RST_WINDOW_CAPACITY;
         dup_thresh_ff <= scwc_pkg::RST_DUP_ACK_THRESH;
         max_rtx_ff    <= scwc_pkg::RST_MAX_RETRANSMITS;
         init_win_ff   <= scwc_pkg::RST_INIT_CLIENT_WIN;
         next_seq_ff   <= '0;
         expected_ff   <= SEQ_W'(1);
         last_ack_ff   <= '0;
         in_flight_ff  <= '0;
         cwnd_ff       <= WIN_W'(1);
         ssthresh_ff   <= scwc_pkg::RST_INIT_CLIENT_WIN;
         acks_left_ff  <= '0;
         dup_cnt_ff    <= '0;
         rtx_cnt_ff    <= '0;
         client_win_ff <= scwc_pkg::RST_INIT_CLIENT_WIN;
         grow_cnt_ff   <= '0;
      end else begin
         capacity_ff   <= capacity_in;
         dup_thresh_ff <= dup_thresh_in;
         max_rtx_ff    <= max_rtx_in;
         init_win_ff   <= init_win_in;
         next_seq_ff   <= next_seq_in;
         expected_ff   <= expected_in;
         last_ack_ff   <= last_ack_in;
         in_flight_ff  <= in_flight_in;
         cwnd_ff       <= cwnd_in;
         ssthresh_ff   <= ssthresh_in;
         acks_left_ff  <= acks_left_in;
         dup_cnt_ff    <= dup_cnt_in;
         rtx_cnt_ff    <= rtx_cnt_in;
         client_win_ff <= client_win_in;
         grow_cnt_ff   <= grow_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      ack_ff     <= ack_in;
      adv_ff     <= adv_in;
      left_ff    <= left_in;
      r_new_ff   <= r_new_in;
      r_first_ff <= r_first_in;
      r_rt_ff    <= r_rt_in;
      r_rtseq_ff <= r_rtseq_in;
      r_probe_ff <= r_probe_in;
      r_timer_ff <= r_timer_in;
      r_gave_ff  <= r_gave_in;
   end

   assign rsp_new_count      = r_new_ff;
   assign rsp_first_new_seq  = r_first_ff;
   assign rsp_retransmit_now = r_rt_ff;
   assign rsp_retransmit_seq = r_rtseq_ff;
   assign rsp_probe_now      = r_probe_ff;
   assign rsp_restart_timer  = r_timer_ff;
   assign rsp_gave_up        = r_gave_ff;
   assign rsp_cwnd_now       = cwnd_ff;
   assign rsp_ssthresh_now   = ssthresh_ff;
   assign rsp_in_flight_now  = in_flight_ff;

endmodule
